// File: sv/rvx_pkg.sv
// Package for the RV32I subset executor: payload structs, decode constants and event codes.
// No dependencies; imported by the stream interfaces and the top level.
`default_nettype none

package rvx_pkg;

  localparam int unsigned XLEN     = 32;
  localparam int unsigned NUM_REGS = 32;
  localparam int unsigned RIDX_W   = $clog2(NUM_REGS);
  localparam int unsigned IMM_BITS = 12;

  // Operation codes of an input item
  localparam logic OP_EXEC   = 1'b0;
  localparam logic OP_PRESET = 1'b1;

  // Opcode / funct fields
  localparam logic [6:0] OPC_REG    = 7'b0110011;
  localparam logic [6:0] OPC_IMM    = 7'b0010011;
  localparam logic [6:0] OPC_SYSTEM = 7'b1110011;
  localparam logic [6:0] F7_SUB     = 7'b0100000;
  localparam logic [6:0] F7_ZERO    = 7'b0000000;
  localparam logic [2:0] F3_ADD     = 3'b000;
  localparam logic [2:0] F3_SRL     = 3'b101;
  localparam logic [2:0] F3_SLL     = 3'b001;

  // The only accepted SYSTEM encoding: ebreak
  localparam logic [XLEN-1:0] EBREAK_WORD = {12'h001, 5'd0, 3'd0, 5'd0, OPC_SYSTEM};

  // Service call registers
  localparam logic [RIDX_W-1:0] REG_A0 = RIDX_W'(10);
  localparam logic [RIDX_W-1:0] REG_A1 = RIDX_W'(11);

  // Service codes held in a0
  localparam logic [XLEN-1:0] SVC_CHAR = XLEN'(1);
  localparam logic [XLEN-1:0] SVC_INT  = XLEN'(2);
  localparam logic [XLEN-1:0] SVC_HALT = XLEN'(3);

  // Result event codes
  localparam logic [2:0] EV_DONE    = 3'd0;
  localparam logic [2:0] EV_CHAR    = 3'd1;
  localparam logic [2:0] EV_INT     = 3'd2;
  localparam logic [2:0] EV_HALT    = 3'd3;
  localparam logic [2:0] EV_ILLEGAL = 3'd4;
  localparam logic [2:0] EV_IGNORED = 3'd5;

  typedef struct packed {
    logic              operation;
    logic [XLEN-1:0]   instruction;
    logic [RIDX_W-1:0] preset_index;
    logic [XLEN-1:0]   preset_value;
  } in_item_t;

  typedef struct packed {
    logic [2:0]        event_res;
    logic [XLEN-1:0]   out_data;
    logic              wrote_register;
    logic [RIDX_W-1:0] dest_index;
    logic [XLEN-1:0]   dest_value;
  } out_item_t;

  function automatic logic [XLEN-1:0] sext_imm(input logic [IMM_BITS-1:0] imm);
    sext_imm = {{(XLEN-IMM_BITS){imm[IMM_BITS-1]}}, imm};
  endfunction

endpackage

`default_nettype wire

// File: sv/rvx_stream_if.sv
// Valid/ready stream interfaces for the executor's input and result channels.
// Depends on rvx_pkg for the payload structs.
`default_nettype none

interface rvx_in_if import rvx_pkg::*; ();
  logic     valid;
  logic     ready;
  in_item_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

interface rvx_out_if import rvx_pkg::*; ();
  logic      valid;
  logic      ready;
  out_item_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

// File: sv/rv32i_subset_executor_top.sv
// RV32I subset executor: register file memory, execute/write-back stage, result register.
// Depends on rvx_pkg and the stream interfaces in rvx_stream_if.sv.
//
// Usage:
//   in_i  : one transfer per item, either an instruction word to execute (ADD, SUB, ADDI,
//           SLLI, SRLI, EBREAK) or a preset of one register.
//   out_o : exactly one result transfer per input item, in order: event code, service data
//           and the register write that the item made.
// Timing:
//   An accepted item is read from the register file into the execute stage registers, is
//   executed and written back there, and its result is registered in the output register.
//   Sustained rate is one item per cycle while out_o.ready is high; the register file has
//   two read ports, one write port, and a one-entry bypass for a write in the read cycle.
// Stall:
//   While a result waits with ready low, the result register holds, the execute stage holds
//   its item and in_i.ready drops once that stage is full; nothing is dropped or repeated.
// Reset:
//   rst_ni clears the per-entry valid bits (all registers read zero), empties the pipeline
//   and sets the block running. No clearing pass is needed. After a halt (EBREAK with a0=3
//   or any illegal item) instructions return event 5 and change nothing; presets still load.
`default_nettype none

module rv32i_subset_executor_top import rvx_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  rvx_in_if.sink    in_i,
  rvx_out_if.source out_o
);

  // Register file: synchronous memory, entries read zero until first written.
  logic [XLEN-1:0] mem_q [NUM_REGS];
  logic [NUM_REGS-1:0] ent_valid_q;

  // Execute stage
  logic              s1_valid_q;
  in_item_t          s1_item_q;
  logic [XLEN-1:0]   rd_a_data_q, rd_b_data_q;
  logic              rd_a_vld_q, rd_b_vld_q;
  logic [RIDX_W-1:0] rd_a_idx_q, rd_b_idx_q;

  // Bypass of the write that happened in the read cycle
  logic              fw_valid_q;
  logic [RIDX_W-1:0] fw_idx_q;
  logic [XLEN-1:0]   fw_val_q;

  logic running_q, running_d;

  // Result register
  logic      out_valid_q;
  out_item_t out_item_q;

  logic              in_fire, s1_adv;
  logic [RIDX_W-1:0] rd_a_idx, rd_b_idx;
  logic              is_ebreak_in;

  logic              wr_en;
  logic [RIDX_W-1:0] wr_idx;
  logic [XLEN-1:0]   wr_val;
  out_item_t         res;

  assign s1_adv  = s1_valid_q && (!out_valid_q || out_o.ready);
  assign in_i.ready = !s1_valid_q || s1_adv;
  assign in_fire = in_i.valid && in_i.ready;

  // Read addresses: ebreak needs a0/a1, everything else rs1/rs2.
  assign is_ebreak_in = (in_i.payload.instruction == EBREAK_WORD);
  assign rd_a_idx = is_ebreak_in ? REG_A0 : in_i.payload.instruction[19:15];
  assign rd_b_idx = is_ebreak_in ? REG_A1 : in_i.payload.instruction[24:20];

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      rd_a_data_q <= mem_q[rd_a_idx];
      rd_b_data_q <= mem_q[rd_b_idx];
      s1_item_q   <= in_i.payload;
      rd_a_idx_q  <= rd_a_idx;
      rd_b_idx_q  <= rd_b_idx;
      fw_idx_q    <= wr_idx;
      fw_val_q    <= wr_val;
    end
    if (wr_en) begin
      mem_q[wr_idx] <= wr_val;
    end
  end

  // Execute and write back
  logic [XLEN-1:0] op_a, op_b, alu_res;
  logic            alu_ok;
  logic [6:0]      opc, f7;
  logic [2:0]      f3;
  logic [RIDX_W-1:0] rd;

  always_comb begin
    opc = s1_item_q.instruction[6:0];
    f3  = s1_item_q.instruction[14:12];
    f7  = s1_item_q.instruction[31:25];
    rd  = s1_item_q.instruction[11:7];

    if (fw_valid_q && fw_idx_q == rd_a_idx_q) op_a = fw_val_q;
    else                                      op_a = rd_a_vld_q ? rd_a_data_q : '0;
    if (fw_valid_q && fw_idx_q == rd_b_idx_q) op_b = fw_val_q;
    else                                      op_b = rd_b_vld_q ? rd_b_data_q : '0;

    alu_ok  = 1'b1;
    alu_res = '0;
    priority if (opc == OPC_REG && f3 == F3_ADD && f7 == F7_ZERO) begin
      alu_res = op_a + op_b;
    end else if (opc == OPC_REG && f3 == F3_ADD && f7 == F7_SUB) begin
      alu_res = op_a - op_b;
    end else if (opc == OPC_IMM && f3 == F3_ADD) begin
      alu_res = op_a + sext_imm(s1_item_q.instruction[31:20]);
    end else if (opc == OPC_IMM && f3 == F3_SLL && f7 == F7_ZERO) begin
      alu_res = op_a << s1_item_q.instruction[24:20];
    end else if (opc == OPC_IMM && f3 == F3_SRL && f7 == F7_ZERO) begin
      alu_res = op_a >> s1_item_q.instruction[24:20];
    end else begin
      alu_ok = 1'b0;
    end

    res       = '0;
    running_d = running_q;
    wr_en     = 1'b0;
    wr_idx    = '0;
    wr_val    = '0;

    if (s1_item_q.operation == OP_PRESET) begin
      if (s1_item_q.preset_index != '0) begin
        wr_en  = s1_adv;
        wr_idx = s1_item_q.preset_index;
        wr_val = s1_item_q.preset_value;
      end
    end else if (!running_q) begin
      res.event_res = EV_IGNORED;
    end else if (alu_ok) begin
      if (rd != '0) begin
        wr_en  = s1_adv;
        wr_idx = rd;
        wr_val = alu_res;
      end
    end else if (s1_item_q.instruction == EBREAK_WORD) begin
      // op_a holds a0, op_b holds a1
      priority if (op_a == SVC_CHAR) begin
        res.event_res = EV_CHAR;
        res.out_data  = {{(XLEN-8){1'b0}}, op_b[7:0]};
      end else if (op_a == SVC_INT) begin
        res.event_res = EV_INT;
        res.out_data  = op_b;
      end else if (op_a == SVC_HALT) begin
        res.event_res = EV_HALT;
        running_d     = 1'b0;
      end else begin
        res.event_res = EV_ILLEGAL;
        running_d     = 1'b0;
      end
    end else begin
      res.event_res = EV_ILLEGAL;
      running_d     = 1'b0;
    end

    if (wr_en) begin
      res.wrote_register = 1'b1;
      res.dest_index     = wr_idx;
      res.dest_value     = wr_val;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ent_valid_q <= '0;
      s1_valid_q  <= 1'b0;
      rd_a_vld_q  <= 1'b0;
      rd_b_vld_q  <= 1'b0;
      fw_valid_q  <= 1'b0;
      running_q   <= 1'b1;
      out_valid_q <= 1'b0;
    end else begin
      if (in_fire) begin
        rd_a_vld_q <= ent_valid_q[rd_a_idx];
        rd_b_vld_q <= ent_valid_q[rd_b_idx];
        fw_valid_q <= wr_en;
      end
      if (wr_en) begin
        ent_valid_q[wr_idx] <= 1'b1;
      end
      if (in_fire) begin
        s1_valid_q <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_q <= 1'b0;
      end
      if (s1_adv) begin
        running_q   <= running_d;
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      out_item_q <= res;
    end
  end

  assign out_o.valid   = out_valid_q;
  assign out_o.payload = out_item_q;

  // x0 is never written
  a_no_x0_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_en |-> wr_idx != '0)
    else $error("write to x0");

  // a halt is final
  a_halt_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !running_q |=> !running_q)
    else $error("block restarted after halt");

  // the execute stage never overwrites an untaken result
  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_adv |-> (!out_valid_q || out_o.ready))
    else $error("result register overrun");

  // ignored events only come while halted
  a_ignored_halted: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_adv && res.event_res == EV_IGNORED) |-> !running_q)
    else $error("instruction ignored while running");

endmodule

`default_nettype wire
